/* rtl/fpr_pkg.sv */
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants for the framed packet receiver
// Frame layout codes, byte kinds, parser phases and the result word layout.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // Framing
  localparam logic [7:0]  START_BYTE       = 8'h7E;
  localparam logic [15:0] RELOAD_DEFAULT   = 16'd200;

  // Defaults for the top-level parameters
  localparam int DEF_HEADER_BYTES    = 10;
  localparam int DEF_MAX_FRAME_BYTES = 512;

  // Header byte positions (frame index, start byte at 0)
  localparam int HDR_ID_HI  = 1;
  localparam int HDR_ID_LO  = 2;
  localparam int HDR_LEN_HI = 4;
  localparam int HDR_LEN_LO = 5;
  localparam int HDR_SRC_HI = 6;
  localparam int HDR_SRC_LO = 7;
  localparam int HDR_SEQ_HI = 8;
  localparam int HDR_SEQ_LO = 9;

  // Byte kind codes on the result side
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_HEADER   = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
  localparam logic [2:0] KIND_CHECK_HI = 3'd3;
  localparam logic [2:0] KIND_CHECK_LO = 3'd4;
  localparam logic [2:0] KIND_DISCARD  = 3'd5;

  // Input mode codes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 4;

  // Parser phase
  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK_HI,
    PH_CHECK_LO
  } fpr_phase_t;

  // One result word
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [8:0]  byte_index;
    logic [2:0]  byte_kind;
    logic        frame_end;
    logic        frame_error;
    logic [15:0] msg_id;
    logic [15:0] payload_length;
    logic [15:0] source_id;
    logic [15:0] sequence_number;
    logic [15:0] received_check;
  } fpr_result_t;

endpackage

/* rtl/fpr_parser.sv */
// ----------------------------------------------------------------------------
// fpr_parser: frame parser state and per-word decode
// Holds the phase, frame position, header words and idle counter; decodes
// one word per cycle into a result and updates the state when go is high.
// ----------------------------------------------------------------------------
module fpr_parser #(
  parameter int HEADER_BYTES    = fpr_pkg::DEF_HEADER_BYTES,
  parameter int MAX_FRAME_BYTES = fpr_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                go,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  output fpr_pkg::fpr_result_t res
);

  // position width: at least the 9 bits of the reported index
  localparam int PW = ($clog2(MAX_FRAME_BYTES) > 9) ? $clog2(MAX_FRAME_BYTES) : 9;
  // compare width for position / length sums
  localparam int CW = 18;

  // state
  logic [15:0]         timeout_reload_r;
  fpr_pkg::fpr_phase_t phase_r, phase_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [15:0]         length_r, length_nxt;
  logic [15:0]         id_r, id_nxt;
  logic [15:0]         src_r, src_nxt;
  logic [15:0]         seq_r, seq_nxt;
  logic [15:0]         check_r, check_nxt;
  logic [15:0]         idle_r, idle_nxt;

  // effective state after a timeout restart
  fpr_pkg::fpr_phase_t ph_eff;
  logic [PW-1:0]       pos_eff;
  logic                timed_out;
  logic [15:0]         len_full;
  logic [15:0]         len_min1;
  logic                len_err;
  logic                hdr_last;
  logic                pay_last;
  logic                is_byte;

  assign is_byte   = (mode == fpr_pkg::MODE_BYTE);
  assign timed_out = (idle_r == 16'd0);
  assign ph_eff    = timed_out ? fpr_pkg::PH_WAIT : phase_r;
  assign pos_eff   = timed_out ? '0 : pos_r;

  // length check on the length low byte
  assign len_full = {length_r[15:8], data_byte};
  assign len_min1 = (len_full == 16'd0) ? 16'd1 : len_full;
  assign len_err  = (ph_eff == fpr_pkg::PH_HEADER) &&
                    (pos_eff == PW'(fpr_pkg::HDR_LEN_LO)) &&
                    ((CW'(HEADER_BYTES) + CW'(len_min1) + CW'(2)) > CW'(MAX_FRAME_BYTES));

  assign hdr_last = (pos_eff == PW'(HEADER_BYTES - 1));
  assign pay_last = (CW'(pos_eff) + CW'(1)) >= (CW'(HEADER_BYTES) + CW'(length_r));

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    length_nxt = length_r;
    id_nxt     = id_r;
    src_nxt    = src_r;
    seq_nxt    = seq_r;
    check_nxt  = check_r;
    idle_nxt   = idle_r;
    if (!is_byte) begin
      if (!timed_out) begin
        idle_nxt = idle_r - 16'd1;
      end
    end else begin
      idle_nxt  = timeout_reload_r;
      phase_nxt = ph_eff;
      pos_nxt   = pos_eff + PW'(1);
      case (ph_eff)
        fpr_pkg::PH_WAIT: begin
          if (data_byte == fpr_pkg::START_BYTE) begin
            phase_nxt  = fpr_pkg::PH_HEADER;
            length_nxt = '0;
            id_nxt     = '0;
            src_nxt    = '0;
            seq_nxt    = '0;
            check_nxt  = '0;
          end else begin
            pos_nxt = '0;
          end
        end
        fpr_pkg::PH_HEADER: begin
          if (pos_eff == PW'(fpr_pkg::HDR_ID_HI))  id_nxt     = {data_byte, 8'd0};
          if (pos_eff == PW'(fpr_pkg::HDR_ID_LO))  id_nxt     = {id_r[15:8], data_byte};
          if (pos_eff == PW'(fpr_pkg::HDR_LEN_HI)) length_nxt = {data_byte, 8'd0};
          if (pos_eff == PW'(fpr_pkg::HDR_LEN_LO)) length_nxt = len_full;
          if (pos_eff == PW'(fpr_pkg::HDR_SRC_HI)) src_nxt    = {data_byte, 8'd0};
          if (pos_eff == PW'(fpr_pkg::HDR_SRC_LO)) src_nxt    = {src_r[15:8], data_byte};
          if (pos_eff == PW'(fpr_pkg::HDR_SEQ_HI)) seq_nxt    = {data_byte, 8'd0};
          if (pos_eff == PW'(fpr_pkg::HDR_SEQ_LO)) seq_nxt    = {seq_r[15:8], data_byte};
          if (len_err) begin
            phase_nxt = fpr_pkg::PH_WAIT;
            pos_nxt   = '0;
          end else if (hdr_last) begin
            phase_nxt = fpr_pkg::PH_PAYLOAD;
          end
        end
        fpr_pkg::PH_PAYLOAD: begin
          if (pay_last) phase_nxt = fpr_pkg::PH_CHECK_HI;
        end
        fpr_pkg::PH_CHECK_HI: begin
          check_nxt = {data_byte, 8'd0};
          phase_nxt = fpr_pkg::PH_CHECK_LO;
        end
        default: begin
          check_nxt = {check_r[15:8], data_byte};
          phase_nxt = fpr_pkg::PH_WAIT;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  // result decode
  always_comb begin
    res                = '0;
    res.byte_value     = data_byte;
    res.byte_index     = pos_eff[8:0];
    res.byte_kind      = fpr_pkg::KIND_DISCARD;
    case (ph_eff)
      fpr_pkg::PH_WAIT: begin
        if (data_byte == fpr_pkg::START_BYTE) res.byte_kind = fpr_pkg::KIND_START;
      end
      fpr_pkg::PH_HEADER: begin
        res.byte_kind = fpr_pkg::KIND_HEADER;
        if (len_err) begin
          res.frame_error    = 1'b1;
          res.payload_length = len_full;
        end
      end
      fpr_pkg::PH_PAYLOAD:  res.byte_kind = fpr_pkg::KIND_PAYLOAD;
      fpr_pkg::PH_CHECK_HI: res.byte_kind = fpr_pkg::KIND_CHECK_HI;
      default: begin
        res.byte_kind       = fpr_pkg::KIND_CHECK_LO;
        res.frame_end       = 1'b1;
        res.msg_id          = id_r;
        res.payload_length  = length_r;
        res.source_id       = src_r;
        res.sequence_number = seq_r;
        res.received_check  = {check_r[15:8], data_byte};
      end
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_reload_r <= fpr_pkg::RELOAD_DEFAULT;
    end else if (cfg_wr_en) begin
      timeout_reload_r <= cfg_wr_data;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fpr_pkg::PH_WAIT;
      pos_r    <= '0;
      length_r <= '0;
      id_r     <= '0;
      src_r    <= '0;
      seq_r    <= '0;
      check_r  <= '0;
      idle_r   <= '0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      length_r <= length_nxt;
      id_r     <= id_nxt;
      src_r    <= src_nxt;
      seq_r    <= seq_nxt;
      check_r  <= check_nxt;
      idle_r   <= idle_nxt;
    end
  end

endmodule

/* rtl/framed_packet_receiver.sv */
// ----------------------------------------------------------------------------
// framed_packet_receiver: byte-stream frame receiver
// An accepted word passes the input register and then the result register.
// Throughput: one word per cycle while the result side is free; tick words
// only update the idle counter, produce no result and never wait on the result side.
// Reset (rst_n, synchronous): pipeline empty, parser waiting for a start
// byte, idle counter zero, timeout reload back to 200.
// ----------------------------------------------------------------------------
module framed_packet_receiver #(
  parameter int HEADER_BYTES    = fpr_pkg::DEF_HEADER_BYTES,
  parameter int MAX_FRAME_BYTES = fpr_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [15:0]                     cfg_wr_data,  // timeout_reload
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fpr_pkg::IN_TDATA_W-1:0]  in_tdata,     // [7:0] data_byte
  input  logic                            in_tuser,     // [0] mode
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] byte_value, [16:8] byte_index, [32:17] msg_id,
  // [48:33] payload_length, [64:49] source_id, [80:65] sequence_number,
  // [96:81] received_check, [103:97] zero
  output logic [fpr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [fpr_pkg::OUT_TUSER_W-1:0] out_tuser,    // [2:0] byte_kind, [3] frame_error
  output logic                            out_tlast     // frame_end
);

  // input register
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       s1_go;
  logic       out_free;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  fpr_pkg::fpr_result_t out_res_r;
  fpr_pkg::fpr_result_t res;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && ((s1_mode_r == fpr_pkg::MODE_TICK) || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
    end
  end

  fpr_parser #(
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .go         (s1_go),
    .mode       (s1_mode_r),
    .data_byte  (s1_byte_r),
    .res        (res)
  );

  // result register control
  assign out_valid_nxt = (out_valid_r && !out_tready) ||
                         (s1_go && (s1_mode_r == fpr_pkg::MODE_BYTE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_mode_r == fpr_pkg::MODE_BYTE)) begin
      out_res_r <= res;
    end
  end

  // pack result word
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.frame_end;
  assign out_tuser  = {out_res_r.frame_error, out_res_r.byte_kind};
  assign out_tdata  = {7'd0,
                       out_res_r.received_check,
                       out_res_r.sequence_number,
                       out_res_r.source_id,
                       out_res_r.payload_length,
                       out_res_r.msg_id,
                       out_res_r.byte_index,
                       out_res_r.byte_value};

endmodule

/* rtl/fpr_checker.sv */
// ----------------------------------------------------------------------------
// fpr_checker: port-level checks for the framed packet receiver
// Watches the result stream and checks word-kind consistency over time.
// ----------------------------------------------------------------------------
module fpr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fpr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [fpr_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // frame end only on the check low byte
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[2:0] == fpr_pkg::KIND_CHECK_LO)
    else $error("frame end on a byte that is not check low");

  // length error only on a header byte at the length low position
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |->
      out_tuser[2:0] == fpr_pkg::KIND_HEADER && !out_tlast &&
      out_tdata[16:8] == 9'(fpr_pkg::HDR_LEN_LO))
    else $error("frame error on an unexpected byte");

  // msg_id, source_id, sequence_number and received_check are zero outside frame end
  a_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[32:17] == 16'd0 && out_tdata[96:49] == 48'd0)
    else $error("header words shown outside frame end");

  // a start byte always sits at index zero
  a_start_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == fpr_pkg::KIND_START |->
      out_tdata[16:8] == 9'd0 && out_tdata[7:0] == fpr_pkg::START_BYTE)
    else $error("start byte with wrong index or value");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
